// File: src/perspective_vertex_project_assert.svh
// Assertion helpers for the vertex projector.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef PERSPECTIVE_VERTEX_PROJECT_ASSERT_SVH
`define PERSPECTIVE_VERTEX_PROJECT_ASSERT_SVH

// Same-cycle implication.
`define PVP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pvp: check failed");

// Next-cycle implication.
`define PVP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pvp: check failed");

`endif

// File: src/pvp_pkg.sv
package pvp_pkg;

  localparam int CoordWidth    = 20;
  localparam int QuatWidth     = 16;
  localparam int QuatFrac      = 14;
  localparam int OutWidth      = 24;
  localparam int DimWidth      = 13;
  localparam int FocalWidth    = 16;
  localparam int CfgDataWidth  = 64;
  localparam int CfgIndexWidth = 3;
  localparam int CamPosWidth   = 3 * CoordWidth;

  // Datapath widths.
  localparam int DeltaWidth  = CoordWidth + 1;
  localparam int Prod1Width  = QuatWidth + DeltaWidth;
  localparam int CrossWidth  = Prod1Width + 2;
  localparam int TWidth      = CoordWidth + 5;
  localparam int Prod2Width  = QuatWidth + TWidth;
  localparam int SumWidth    = Prod2Width + 2;
  localparam int CamWidth    = CoordWidth + 8;
  localparam int DepthWidth  = CoordWidth + 7;
  localparam int NumWidth    = CamWidth + DimWidth + 1;
  localparam int ScaledWidth = NumWidth + FocalWidth + 1;
  localparam int DivWidth    = ScaledWidth - 2;
  localparam int RemWidth    = DepthWidth + 1;
  localparam int ProjWidth   = 41;
  localparam int SatWidth    = ProjWidth + 2;
  localparam int CenterWidth = DimWidth + 7;
  localparam int RoundHalf   = 1 << (QuatFrac - 1);

  localparam logic [ProjWidth-1:0] ProjCap = ProjWidth'(1) << (ProjWidth - 1);

  localparam logic [CamPosWidth-1:0]  CamPosReset  = '0;
  localparam logic [CfgDataWidth-1:0] RotReset     = 64'h4000_0000_0000_0000;
  localparam logic [FocalWidth-1:0]   FocalReset   = 16'd443;
  localparam logic [DimWidth-1:0]     WidthReset   = 13'd640;
  localparam logic [DimWidth-1:0]     HeightReset  = 13'd480;

  localparam int unsigned MidQueueDepth = 4;
  localparam int unsigned OutQueueDepth = 4;

  typedef enum logic [CfgIndexWidth-1:0] {
    RegCamPos       = 3'd0,
    RegViewRotation = 3'd1,
    RegFocalScale   = 3'd2,
    RegScreenWidth  = 3'd3,
    RegScreenHeight = 3'd4
  } pvp_reg_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic signed [CoordWidth-1:0] point_z;
  } pvp_point_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] screen_x;
    logic signed [OutWidth-1:0] screen_y;
    logic                       behind;
  } pvp_result_t;

  // Camera-space point handed from front to back.
  typedef struct packed {
    logic signed [CamWidth-1:0] cx;
    logic signed [CamWidth-1:0] cy;
    logic signed [CamWidth-1:0] cz;
    logic                       behind;
  } pvp_cam_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] cam_x;
    logic signed [CoordWidth-1:0] cam_y;
    logic signed [CoordWidth-1:0] cam_z;
    logic signed [QuatWidth-1:0]  quat_w;
    logic signed [QuatWidth-1:0]  quat_x;
    logic signed [QuatWidth-1:0]  quat_y;
    logic signed [QuatWidth-1:0]  quat_z;
    logic [FocalWidth-1:0]        focal;
    logic [DimWidth-1:0]          screen_w;
    logic [DimWidth-1:0]          screen_h;
  } pvp_cfg_t;

endpackage

// File: src/perspective_vertex_project.sv
// Perspective vertex projector: world point -> camera space -> screen pixels.
// Throughput: one vertex per cycle while the middle queue is not full; the back
// end's 57-step restoring divider is fully pipelined, one quotient bit per stage,
// and stalls only while the output queue is full.
// Reset (rst_ni low, asynchronous): both queues and all stage valids clear;
// the registers return to camera at origin, identity rotation, 443, 640x480.
module perspective_vertex_project import pvp_pkg::*; #(
  parameter int unsigned MidDepth = MidQueueDepth,
  parameter int unsigned OutDepth = OutQueueDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // vertex input, queue style
  input  logic                     push,
  output logic                     full,
  input  pvp_point_t               point_i,
  // result output, queue style
  output logic                     empty,
  input  logic                     pop,
  output pvp_result_t              result_o,
  // register writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i
);

  // Enough for every stage and queue slot between input and output.
  localparam int unsigned InflightWidth = 8;

  // Register file. Writes only land while the pipe is idle, so the datapath
  // reads these directly without any shadow copy.
  logic [CamPosWidth-1:0]  cam_pos_q;
  logic [CfgDataWidth-1:0] rot_q;
  logic [FocalWidth-1:0]   focal_q;
  logic [DimWidth-1:0]     screen_w_q;
  logic [DimWidth-1:0]     screen_h_q;
  pvp_cfg_t                cfg;

  // Items accepted and not yet popped
  logic                     in_xfer, out_xfer;
  logic [InflightWidth-1:0] inflight_d, inflight_q;

  // Front/back handshake
  logic      front_en, front_valid;
  pvp_cam_t  front_item;
  logic      mid_full, mid_empty, mid_pop;
  pvp_cam_t  mid_item;
  logic      back_en, back_valid;
  pvp_result_t back_result;
  logic      out_full;

  assign in_xfer  = push && !full;
  assign out_xfer = pop && !empty;

  always_comb begin
    inflight_d = inflight_q;
    case ({in_xfer, out_xfer})
      2'b10:   inflight_d = inflight_q + 1'b1;
      2'b01:   inflight_d = inflight_q - 1'b1;
      default: ;
    endcase
  end

  // A register transfer is taken only with nothing in flight and no vertex
  // offered in the same cycle, so every item sees one settled setup.
  assign cfg_ready_o = (inflight_q == '0) && !push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_pos_q  <= CamPosReset;
      rot_q      <= RotReset;
      focal_q    <= FocalReset;
      screen_w_q <= WidthReset;
      screen_h_q <= HeightReset;
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (pvp_reg_e'(cfg_index_i))
          RegCamPos:       cam_pos_q  <= cfg_data_i[CamPosWidth-1:0];
          RegViewRotation: rot_q      <= cfg_data_i;
          RegFocalScale:   focal_q    <= cfg_data_i[FocalWidth-1:0];
          RegScreenWidth:  screen_w_q <= cfg_data_i[DimWidth-1:0];
          RegScreenHeight: screen_h_q <= cfg_data_i[DimWidth-1:0];
          default: ;  // unmapped index, transfer dropped
        endcase
      end
    end
  end

  always_comb begin
    cfg.cam_x    = cam_pos_q[3*CoordWidth-1:2*CoordWidth];
    cfg.cam_y    = cam_pos_q[2*CoordWidth-1:CoordWidth];
    cfg.cam_z    = cam_pos_q[CoordWidth-1:0];
    cfg.quat_w   = rot_q[63:48];
    cfg.quat_x   = rot_q[47:32];
    cfg.quat_y   = rot_q[31:16];
    cfg.quat_z   = rot_q[15:0];
    cfg.focal    = focal_q;
    cfg.screen_w = screen_w_q;
    cfg.screen_h = screen_h_q;
  end

  // Front: translate, rotate, flag points behind the camera. It moves as one
  // lockstep pipe and stops only when the middle queue is full.
  assign front_en = !mid_full;
  assign full     = mid_full;

  pvp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (front_en),
    .valid_i (push && !mid_full),
    .point_i (point_i),
    .cfg_i   (cfg),
    .valid_o (front_valid),
    .item_o  (front_item)
  );

  pvp_fifo #(
    .ItemT (pvp_cam_t),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .write_i (front_en && front_valid),
    .wdata_i (front_item),
    .read_i  (mid_pop),
    .rdata_o (mid_item),
    .empty_o (mid_empty),
    .full_o  (mid_full)
  );

  // Back: scale, divide by depth, center and saturate. Stalls only on a
  // full output queue; the queue decouples it from the consumer.
  assign back_en = !out_full;
  assign mid_pop = back_en && !mid_empty;

  pvp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (back_en),
    .valid_i  (mid_pop),
    .item_i   (mid_item),
    .cfg_i    (cfg),
    .valid_o  (back_valid),
    .result_o (back_result)
  );

  pvp_fifo #(
    .ItemT (pvp_result_t),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .write_i (back_en && back_valid),
    .wdata_i (back_result),
    .read_i  (out_xfer),
    .rdata_o (result_o),
    .empty_o (empty),
    .full_o  (out_full)
  );

endmodule

// File: src/pvp_fifo.sv
module pvp_fifo import pvp_pkg::*; #(
  parameter type ItemT = pvp_cam_t,
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic write_i,
  input  ItemT wdata_i,
  input  logic read_i,
  output ItemT rdata_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  ItemT                mem_q [Depth];
  logic [PtrWidth-1:0] wptr_q, rptr_q;
  logic [CntWidth-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (write_i) begin
        wptr_q <= (wptr_q == PtrWidth'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (read_i) begin
        rptr_q <= (rptr_q == PtrWidth'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({write_i, read_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (write_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntWidth'(Depth));

endmodule

// File: src/pvp_front.sv
module pvp_front import pvp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  pvp_point_t point_i,
  input  pvp_cfg_t   cfg_i,
  output logic       valid_o,
  output pvp_cam_t   item_o
);

  typedef logic signed [DeltaWidth-1:0] delta_t;

  logic [4:0]                    valid_q;
  delta_t                        d_q [4][3];
  logic signed [Prod1Width-1:0]  p1_q [6];
  logic signed [TWidth-1:0]      t_q [3];
  logic signed [Prod2Width-1:0]  p2_q [9];
  pvp_cam_t                      item_q;

  delta_t                        d_in [3];
  logic signed [CamWidth-1:0]    c_d [3];
  pvp_cam_t                      item_d;

  // round half up, drop the quaternion fraction
  function automatic logic signed [TWidth-1:0] rnd_cross(input logic signed [CrossWidth-1:0] v);
    logic signed [CrossWidth-1:0] s;
    s = (v + CrossWidth'(RoundHalf)) >>> QuatFrac;
    return s[TWidth-1:0];
  endfunction

  function automatic logic signed [CamWidth-1:0] rnd_sum(input logic signed [SumWidth-1:0] v);
    logic signed [SumWidth-1:0] s;
    s = (v + SumWidth'(RoundHalf)) >>> QuatFrac;
    return s[CamWidth-1:0];
  endfunction

  function automatic logic signed [Prod1Width-1:0] mul1(input logic signed [QuatWidth-1:0] q,
                                                        input delta_t d);
    return Prod1Width'(q) * Prod1Width'(d);
  endfunction

  function automatic logic signed [Prod2Width-1:0] mul2(input logic signed [QuatWidth-1:0] q,
                                                        input logic signed [TWidth-1:0] t);
    return Prod2Width'(q) * Prod2Width'(t);
  endfunction

  function automatic logic signed [CrossWidth-1:0] twice_diff(
      input logic signed [Prod1Width-1:0] a, input logic signed [Prod1Width-1:0] b);
    logic signed [CrossWidth-1:0] s;
    s = CrossWidth'(a) - CrossWidth'(b);
    return s <<< 1;
  endfunction

  function automatic logic signed [SumWidth-1:0] rot_sum(input logic signed [Prod2Width-1:0] a,
      input logic signed [Prod2Width-1:0] b, input logic signed [Prod2Width-1:0] c);
    return SumWidth'(a) + SumWidth'(b) - SumWidth'(c);
  endfunction

  always_comb begin
    d_in[0] = DeltaWidth'(point_i.point_x) - DeltaWidth'(cfg_i.cam_x);
    d_in[1] = DeltaWidth'(point_i.point_y) - DeltaWidth'(cfg_i.cam_y);
    d_in[2] = DeltaWidth'(point_i.point_z) - DeltaWidth'(cfg_i.cam_z);

    c_d[0] = CamWidth'(d_q[3][0]) + rnd_sum(rot_sum(p2_q[0], p2_q[3], p2_q[4]));
    c_d[1] = CamWidth'(d_q[3][1]) + rnd_sum(rot_sum(p2_q[1], p2_q[5], p2_q[6]));
    c_d[2] = CamWidth'(d_q[3][2]) + rnd_sum(rot_sum(p2_q[2], p2_q[7], p2_q[8]));

    item_d.cx     = c_d[0];
    item_d.cy     = c_d[1];
    item_d.cz     = c_d[2];
    item_d.behind = c_d[2][CamWidth-1] || (c_d[2] == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q[0] <= d_in;
      d_q[1] <= d_q[0];
      d_q[2] <= d_q[1];
      d_q[3] <= d_q[2];
      // u x d terms
      p1_q[0] <= mul1(cfg_i.quat_y, d_q[0][2]);
      p1_q[1] <= mul1(cfg_i.quat_z, d_q[0][1]);
      p1_q[2] <= mul1(cfg_i.quat_z, d_q[0][0]);
      p1_q[3] <= mul1(cfg_i.quat_x, d_q[0][2]);
      p1_q[4] <= mul1(cfg_i.quat_x, d_q[0][1]);
      p1_q[5] <= mul1(cfg_i.quat_y, d_q[0][0]);
      t_q[0]  <= rnd_cross(twice_diff(p1_q[0], p1_q[1]));
      t_q[1]  <= rnd_cross(twice_diff(p1_q[2], p1_q[3]));
      t_q[2]  <= rnd_cross(twice_diff(p1_q[4], p1_q[5]));
      // w*t and u x t terms
      p2_q[0] <= mul2(cfg_i.quat_w, t_q[0]);
      p2_q[1] <= mul2(cfg_i.quat_w, t_q[1]);
      p2_q[2] <= mul2(cfg_i.quat_w, t_q[2]);
      p2_q[3] <= mul2(cfg_i.quat_y, t_q[2]);
      p2_q[4] <= mul2(cfg_i.quat_z, t_q[1]);
      p2_q[5] <= mul2(cfg_i.quat_z, t_q[0]);
      p2_q[6] <= mul2(cfg_i.quat_x, t_q[2]);
      p2_q[7] <= mul2(cfg_i.quat_x, t_q[1]);
      p2_q[8] <= mul2(cfg_i.quat_y, t_q[0]);
      item_q  <= item_d;
    end
  end

  assign valid_o = valid_q[4];
  assign item_o  = item_q;

endmodule

// File: src/pvp_back.sv
module pvp_back import pvp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  pvp_cam_t    item_i,
  input  pvp_cfg_t    cfg_i,
  output logic        valid_o,
  output pvp_result_t result_o
);

  typedef struct packed {
    logic [RemWidth-1:0]  rem;
    logic [DivWidth-1:0]  numr;
    logic [ProjWidth-1:0] quot;
    logic                 ovf;
    logic                 neg;
  } lane_t;

  localparam logic signed [SatWidth-1:0] SatHi = SatWidth'((1 << (OutWidth - 1)) - 1);
  localparam logic signed [SatWidth-1:0] SatLo = -SatHi - SatWidth'(1);

  logic [1:0]                     pre_valid_q;
  logic [DivWidth:0]              div_valid_q;
  logic signed [NumWidth-1:0]     num_x_q, num_y_q;
  logic signed [ScaledWidth-1:0]  sc_x_q, sc_y_q;
  logic [DepthWidth-1:0]          z1_q, z2_q;
  logic [1:0]                     pre_behind_q;
  lane_t                          x_q [DivWidth+1];
  lane_t                          y_q [DivWidth+1];
  logic [DepthWidth-1:0]          z_q [DivWidth+1];
  logic [DivWidth:0]              behind_q;

  function automatic lane_t load(input logic signed [ScaledWidth-1:0] sc,
                                 input logic [DepthWidth-1:0] z);
    lane_t                   l;
    logic [ScaledWidth-1:0]  mag;
    mag    = sc[ScaledWidth-1] ? ScaledWidth'(-sc) : ScaledWidth'(sc);
    l.rem  = '0;
    l.quot = '0;
    l.ovf  = 1'b0;
    l.neg  = sc[ScaledWidth-1];
    // half the divisor added for round to nearest
    l.numr = mag[DivWidth-1:0] + DivWidth'(z >> 1);
    return l;
  endfunction

  function automatic lane_t div_step(input lane_t l, input logic [DepthWidth-1:0] z);
    lane_t               n;
    logic [RemWidth-1:0] trial;
    n      = l;
    trial  = {l.rem[RemWidth-2:0], l.numr[DivWidth-1]};
    n.numr = {l.numr[DivWidth-2:0], 1'b0};
    n.ovf  = l.ovf | l.quot[ProjWidth-1];
    if (trial >= {1'b0, z}) begin
      n.rem  = trial - {1'b0, z};
      n.quot = {l.quot[ProjWidth-2:0], 1'b1};
    end else begin
      n.rem  = trial;
      n.quot = {l.quot[ProjWidth-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic logic signed [OutWidth-1:0] finish(input lane_t l,
                                                       input logic [DimWidth-1:0] dim);
    logic [ProjWidth-1:0]        val;
    logic signed [SatWidth-1:0]  s;
    val = (l.ovf || (l.quot[ProjWidth-1] && |l.quot[ProjWidth-2:0])) ? ProjCap : l.quot;
    s   = $signed({2'b00, val});
    if (l.neg) begin
      s = -s;
    end
    s = s + $signed(SatWidth'({dim, 7'b0}));
    if (s > SatHi) begin
      s = SatHi;
    end else if (s < SatLo) begin
      s = SatLo;
    end
    return s[OutWidth-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= '0;
      div_valid_q <= '0;
    end else if (en_i) begin
      pre_valid_q <= {pre_valid_q[0], valid_i};
      div_valid_q <= {div_valid_q[DivWidth-1:0], pre_valid_q[1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_x_q <= NumWidth'(item_i.cx) * NumWidth'($signed({1'b0, cfg_i.screen_h}));
      num_y_q <= NumWidth'(item_i.cy) * NumWidth'($signed({1'b0, cfg_i.screen_h}));
      z1_q    <= item_i.cz[DepthWidth-1:0];
      sc_x_q  <= ScaledWidth'(num_x_q) * ScaledWidth'($signed({1'b0, cfg_i.focal}));
      sc_y_q  <= ScaledWidth'(num_y_q) * ScaledWidth'($signed({1'b0, cfg_i.focal}));
      z2_q    <= z1_q;
      pre_behind_q <= {pre_behind_q[0], item_i.behind};
      x_q[0]  <= load(sc_x_q, z2_q);
      y_q[0]  <= load(sc_y_q, z2_q);
      z_q[0]  <= z2_q;
      behind_q[0] <= pre_behind_q[1];
      for (int k = 0; k < DivWidth; k++) begin
        x_q[k+1]      <= div_step(x_q[k], z_q[k]);
        y_q[k+1]      <= div_step(y_q[k], z_q[k]);
        z_q[k+1]      <= z_q[k];
        behind_q[k+1] <= behind_q[k];
      end
    end
  end

  always_comb begin
    if (behind_q[DivWidth]) begin
      result_o.screen_x = '0;
      result_o.screen_y = '0;
      result_o.behind   = 1'b1;
    end else begin
      result_o.screen_x = finish(x_q[DivWidth], cfg_i.screen_w);
      result_o.screen_y = finish(y_q[DivWidth], cfg_i.screen_h);
      result_o.behind   = 1'b0;
    end
  end

  assign valid_o = div_valid_q[DivWidth];

endmodule

// File: src/pvp_checker.sv
`include "perspective_vertex_project_assert.svh"

module pvp_props import pvp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full_i,
  input logic        empty_i,
  input logic        pop_i,
  input pvp_result_t res_i
);

  // a waiting result is not dropped or changed before its transfer
  `PVP_ASSERT_NEXT(held_result_a, !empty_i && !pop_i, !empty_i && $stable(res_i))
  // behind-camera results carry zero coordinates
  `PVP_ASSERT_IMPL(behind_zero_a, !empty_i && res_i.behind, {res_i.screen_x, res_i.screen_y} == '0)
  // the output queue comes out of reset empty and the middle queue not full
  `PVP_ASSERT_IMPL(reset_clear_a, $rose(rst_ni), empty_i && !full_i)

endmodule

bind perspective_vertex_project pvp_props u_pvp_props (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .full_i  (full),
  .empty_i (empty),
  .pop_i   (pop),
  .res_i   (result_o)
);
